/* rtl/ulaw_noise_gate_lookback_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the u-law noise gate
// Shared clocking for the concurrent checks, with or without reset handling.
// ----------------------------------------------------------------------------
`ifndef ULAW_NOISE_GATE_LOOKBACK_TOP_MACROS_SVH
`define ULAW_NOISE_GATE_LOOKBACK_TOP_MACROS_SVH

// check on every rising edge, skipped while reset is high
`define NGL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check on every rising edge, reset included
`define NGL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/ngl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngl_pkg
// Constants, register codes and shared types of the u-law noise gate.
// ----------------------------------------------------------------------------
package ngl_pkg;

  localparam int MAX_HOLD_DEF = 63;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DELETE_SILENCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOUD_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LEN       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_CODE   = 2'd3;

  localparam logic       RST_DELETE_SILENCE = 1'b0;
  localparam logic [6:0] RST_LOUD_THRESHOLD = 7'd32;
  localparam logic [5:0] RST_HOLD_LEN       = 6'd63;
  localparam logic [7:0] RST_SILENCE_CODE   = 8'hFF;

  localparam logic [7:0] MAG_MASK = 8'h7F;

  typedef struct packed {
    logic       delete_silence;
    logic [6:0] loud_threshold;
    logic [7:0] silence_code;
  } cfg_t;

endpackage

/* rtl/ngl_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngl_ring
// Hold ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ngl_ring #(
  parameter int DEPTH = 63,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ngl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngl_ctrl
// Gate sequencer: decides per sample, fills the hold ring, replays it on an
// opening and drives the registered output.
// ----------------------------------------------------------------------------
`include "ulaw_noise_gate_lookback_top_macros.svh"

module ngl_ctrl import ngl_pkg::*; #(
  parameter int MAX_HOLD = MAX_HOLD_DEF,
  parameter int CW       = $clog2(MAX_HOLD + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic [CW-1:0] len,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    sample_in,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    sample_out,
  output logic          last
);

  localparam int AW = (MAX_HOLD > 1) ? $clog2(MAX_HOLD) : 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PROC   = 4'b0010,
    S_REPLAY = 4'b0100,
    S_FINAL  = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic          gate_open, gate_open_next;
  logic [CW-1:0] quiet_run, quiet_run_next;
  logic [CW:0]   skip_count, skip_count_next;
  logic [CW-1:0] ring_ptr, ring_ptr_next;
  logic [CW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] rep_cnt, rep_cnt_next;
  logic [7:0]    samp;
  logic          out_valid_next;
  logic [7:0]    sample_out_next;
  logic          last_next;

  logic          slot_free;
  logic          loud;
  logic [CW-1:0] ptr_n;
  logic [CW-1:0] cnt;
  logic [CW:0]   start_w;
  logic [CW-1:0] start;
  logic [CW:0]   skip_inc;
  logic [CW:0]   len1;
  logic [CW:0]   skip_new;
  logic          emit_sil;
  logic [CW:0]   q;
  logic          close_gate;

  logic          ring_we;
  logic          ring_re;
  logic [AW-1:0] ring_waddr;
  logic [AW-1:0] ring_raddr;
  logic [7:0]    ring_rdata;

  function automatic logic [CW-1:0] wrap_inc(logic [CW-1:0] v, logic [CW-1:0] n);
    logic [CW:0] sum;
    sum = {1'b0, v} + 1'b1;
    return (sum >= {1'b0, n}) ? '0 : sum[CW-1:0];
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  assign loud     = (samp & MAG_MASK) <= {1'b0, cfg.loud_threshold};
  assign ptr_n    = (ring_ptr >= len) ? '0 : ring_ptr;
  assign cnt      = (skip_count < {1'b0, len}) ? skip_count[CW-1:0] : len;
  assign start_w  = (cnt > ptr_n) ? ({1'b0, ptr_n} + {1'b0, len} - {1'b0, cnt})
                                  : ({1'b0, ptr_n} - {1'b0, cnt});
  assign start    = start_w[CW-1:0];
  assign skip_inc = skip_count + 1'b1;
  assign len1     = {1'b0, len} + 1'b1;
  assign skip_new = (skip_inc > len1) ? len1 : skip_inc;
  assign emit_sil = !cfg.delete_silence && (skip_new > {1'b0, len});
  assign q          = {1'b0, quiet_run} + 1'b1;
  assign close_gate = q >= {1'b0, len};

  always_comb begin
    state_next      = state;
    gate_open_next  = gate_open;
    quiet_run_next  = quiet_run;
    skip_count_next = skip_count;
    ring_ptr_next   = ring_ptr;
    rd_ptr_next     = rd_ptr;
    rep_cnt_next    = rep_cnt;
    out_valid_next  = out_valid && out_stall;
    sample_out_next = sample_out;
    last_next       = last;
    ring_we         = 1'b0;
    ring_re         = 1'b0;
    ring_waddr      = ptr_n[AW-1:0];
    ring_raddr      = rd_ptr[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_PROC;
        end
      end
      S_PROC: begin
        if (gate_open) begin
          if (slot_free) begin
            out_valid_next  = 1'b1;
            sample_out_next = samp;
            last_next       = 1'b1;
            if (loud) begin
              quiet_run_next = '0;
            end else if (close_gate) begin
              gate_open_next  = 1'b0;
              quiet_run_next  = '0;
              skip_count_next = '0;
              ring_ptr_next   = '0;
            end else begin
              quiet_run_next = q[CW-1:0];
            end
            state_next = S_IDLE;
          end
        end else if (loud) begin
          ring_ptr_next = ptr_n;
          if (cnt == '0) begin
            state_next = S_FINAL;
          end else begin
            ring_re      = 1'b1;
            ring_raddr   = start[AW-1:0];
            rd_ptr_next  = wrap_inc(start, len);
            rep_cnt_next = cnt;
            state_next   = S_REPLAY;
          end
        end else if (!emit_sil || slot_free) begin
          ring_we         = 1'b1;
          ring_ptr_next   = wrap_inc(ptr_n, len);
          skip_count_next = skip_new;
          if (emit_sil) begin
            out_valid_next  = 1'b1;
            sample_out_next = cfg.silence_code;
            last_next       = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_REPLAY: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          sample_out_next = ring_rdata;
          last_next       = 1'b0;
          rep_cnt_next    = rep_cnt - 1'b1;
          if (rep_cnt == CW'(1)) begin
            state_next = S_FINAL;
          end else begin
            ring_re     = 1'b1;
            rd_ptr_next = wrap_inc(rd_ptr, len);
          end
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          sample_out_next = samp;
          last_next       = 1'b1;
          gate_open_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      gate_open  <= 1'b0;
      quiet_run  <= CW'(MAX_HOLD);
      skip_count <= '0;
      ring_ptr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      gate_open  <= gate_open_next;
      quiet_run  <= quiet_run_next;
      skip_count <= skip_count_next;
      ring_ptr   <= ring_ptr_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      samp <= sample_in;
    end
    rd_ptr     <= rd_ptr_next;
    rep_cnt    <= rep_cnt_next;
    sample_out <= sample_out_next;
    last       <= last_next;
  end

  ngl_ring #(
    .DEPTH (MAX_HOLD),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (samp),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  `NGL_ASSERT(a_ring_one_port, !(ring_we && ring_re), "ring read and write in one cycle")
  `NGL_ASSERT(a_read_state, ring_re |-> (state == S_PROC || state == S_REPLAY), "stray ring read")
  `NGL_ASSERT(a_replay_cnt, (state == S_REPLAY) |-> (rep_cnt != '0), "replay with empty count")
  `NGL_ASSERT(a_final_last, (state == S_FINAL && slot_free) |=> (out_valid && last), "opening lost")
  `NGL_ASSERT(a_open_src, $rose(gate_open) |-> $past(state == S_FINAL), "gate opened outside final")

endmodule

/* rtl/ulaw_noise_gate_lookback_top.sv */
`timescale 1ns / 1ps
// Flow: a request is taken only in idle; the processing state registers its passed or
// silence byte when the output is free. An opening with n <= hold_len buffered bytes
// replays them, one ring read and one output byte per cycle while the output is free.
// Reset (rst, synchronous): gate closed, quiet count at full length, ring empty,
// registers back to delete 0, threshold 32, hold 63, silence code 0xFF.
// ----------------------------------------------------------------------------
// ulaw_noise_gate_lookback_top
// u-law noise gate with look-back ring: configuration registers and sequencer.
// ----------------------------------------------------------------------------
module ulaw_noise_gate_lookback_top import ngl_pkg::*; #(
  parameter int MAX_HOLD = MAX_HOLD_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            sample_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            sample_out,
  output logic                  last
);

  localparam int CW = $clog2(MAX_HOLD + 1);

  cfg_t          cfg;
  logic [5:0]    hold_len;
  logic [5:0]    hold_nz;
  logic [5:0]    hold_eff;
  logic [CW-1:0] len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delete_silence <= RST_DELETE_SILENCE;
      cfg.loud_threshold <= RST_LOUD_THRESHOLD;
      hold_len           <= RST_HOLD_LEN;
      cfg.silence_code   <= RST_SILENCE_CODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DELETE_SILENCE: cfg.delete_silence <= cfg_data[0];
        CFG_LOUD_THRESHOLD: cfg.loud_threshold <= cfg_data[6:0];
        CFG_HOLD_LEN:       hold_len           <= cfg_data[5:0];
        CFG_SILENCE_CODE:   cfg.silence_code   <= cfg_data[7:0];
      endcase
    end
  end

  assign hold_nz  = (hold_len == '0) ? 6'd1 : hold_len;
  assign hold_eff = (hold_nz > 6'(MAX_HOLD)) ? 6'(MAX_HOLD) : hold_nz;
  assign len      = hold_eff[CW-1:0];

  ngl_ctrl #(
    .MAX_HOLD (MAX_HOLD),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .len        (len),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .last       (last)
  );

endmodule

/* sim/ulaw_noise_gate_lookback_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulaw_noise_gate_lookback_top_test
// Self-checking bench for the u-law noise gate. A directed table covers the
// first opening, the threshold boundary, ring replay with wrap, silence
// substitution and deletion, and a zero hold length. Random phases follow,
// with quiet/loud bursts around the hold length under several register
// settings. Every accepted request runs through a local gate model; output
// bytes are checked in order against the model's bytes, or the row's typed outcome.
// ----------------------------------------------------------------------------
module ulaw_noise_gate_lookback_top_test;
  import ngl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  // known = 1: outcome typed in the row (no byte, or one byte with last set)
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [7:0]             val;
    logic                   known;
    logic                   has_out;
    logic [7:0]             exp_out;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       last;
  } gate_byte_t;

  localparam int N_DIR = 36;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h7F, 1'b1, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'hFF, 1'b1, 1'b1, 8'hFF},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'hA0, 1'b1, 1'b1, 8'hA0},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h21, 1'b1, 1'b1, 8'h21},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h80, 1'b1, 1'b1, 8'h80},
    '{ROW_CFG,    CFG_HOLD_LEN,       8'h02, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,    CFG_SILENCE_CODE,   8'h55, 1'b0, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'hC5, 1'b1, 1'b1, 8'hC5},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h6A, 1'b1, 1'b1, 8'h6A},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h40, 1'b1, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h41, 1'b1, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h42, 1'b1, 1'b1, 8'h55},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h43, 1'b1, 1'b1, 8'h55},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h01, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,    CFG_DELETE_SILENCE, 8'h01, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,    CFG_LOUD_THRESHOLD, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,    CFG_HOLD_LEN,       8'h01, 1'b0, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h81, 1'b1, 1'b1, 8'h81},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h7E, 1'b1, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'hFE, 1'b1, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h80, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,    CFG_DELETE_SILENCE, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,    CFG_LOUD_THRESHOLD, 8'h7F, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,    CFG_SILENCE_CODE,   8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,    CFG_HOLD_LEN,       8'h3F, 1'b0, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'hFF, 1'b1, 1'b1, 8'hFF},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h00, 1'b1, 1'b1, 8'h00},
    '{ROW_CFG,    CFG_LOUD_THRESHOLD, 8'h20, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,    CFG_HOLD_LEN,       8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h7F, 1'b1, 1'b1, 8'h7F},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h33, 1'b1, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h34, 1'b1, 1'b1, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h9F, 1'b0, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'hE0, 1'b0, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_DELETE_SILENCE, 8'h5F, 1'b0, 1'b0, 8'h00}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            sample_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            sample_out;
  logic                  last;

  ulaw_noise_gate_lookback_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .last       (last)
  );

  // gate model state and register copies
  logic       cf_delete;
  logic [6:0] cf_thr;
  logic [5:0] cf_hold;
  logic [7:0] cf_silence;
  logic       gm_open;
  logic [5:0] gm_quiet;
  logic [6:0] gm_skip;
  logic [5:0] gm_ptr;
  logic [7:0] gm_ring [MAX_HOLD_DEF];

  gate_byte_t  step_bytes [$];
  gate_byte_t  pending_bytes [$];
  dir_row_t    offered_rows [$];
  int unsigned fault_count = 0;
  int unsigned cycles = 0;
  int unsigned hold_off_asks = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned hold_in_use();
    return (cf_hold == 6'd0) ? 1 : cf_hold;
  endfunction

  task automatic gate_step(input logic [7:0] s);
    int unsigned len, cnt, p, q;
    logic        loud;
    step_bytes.delete();
    len = hold_in_use();
    loud = (s & MAG_MASK) <= {1'b0, cf_thr};
    if (gm_open) begin
      if (loud) begin
        gm_quiet = '0;
      end else begin
        q = gm_quiet + 1;
        if (q >= len) begin
          gm_open = 1'b0;
          gm_quiet = '0;
          gm_skip = '0;
          gm_ptr = '0;
        end else begin
          gm_quiet = q[5:0];
        end
      end
      step_bytes.push_back({s, 1'b1});
    end else begin
      if (gm_ptr >= len) gm_ptr = '0;
      if (loud) begin
        cnt = (gm_skip < len) ? gm_skip : len;
        p = gm_ptr;
        p = (cnt > p) ? p + len - cnt : p - cnt;
        repeat (cnt) begin
          step_bytes.push_back({gm_ring[p], 1'b0});
          p++;
          if (p >= len) p = 0;
        end
        gm_ptr = p[5:0];
        step_bytes.push_back({s, 1'b1});
        gm_open = 1'b1;
      end else begin
        gm_ring[gm_ptr] = s;
        p = gm_ptr + 1;
        gm_ptr = (p >= len) ? 6'd0 : p[5:0];
        q = gm_skip + 1;
        if (q > len + 1) q = len + 1;
        gm_skip = q[6:0];
        if (!cf_delete && gm_skip > len) step_bytes.push_back({cf_silence, 1'b1});
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    dir_row_t   row;
    gate_byte_t want;
    if (rst) begin
      cf_delete = RST_DELETE_SILENCE;
      cf_thr = RST_LOUD_THRESHOLD;
      cf_hold = RST_HOLD_LEN;
      cf_silence = RST_SILENCE_CODE;
      gm_open = 1'b0;
      gm_quiet = RST_HOLD_LEN;
      gm_skip = '0;
      gm_ptr = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DELETE_SILENCE: cf_delete = cfg_data[0];
          CFG_LOUD_THRESHOLD: cf_thr = cfg_data[6:0];
          CFG_HOLD_LEN:       cf_hold = cfg_data[5:0];
          CFG_SILENCE_CODE:   cf_silence = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        row = offered_rows.pop_front();
        gate_step(sample_in);
        if (row.known) begin
          if (row.has_out) pending_bytes.push_back({row.exp_out, 1'b1});
        end else begin
          foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_bytes.size() == 0) begin
          $error("sample_out: no byte pending, got %02h (last %0b)", sample_out, last);
          fault_count++;
        end else begin
          want = pending_bytes.pop_front();
          if (sample_out !== want.sample) begin
            $error("sample_out: expected %02h, got %02h", want.sample, sample_out);
            fault_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            fault_count++;
          end
        end
      end
    end
  end

  // output back-pressure: short and long stalls, free stretches, requested hold-offs
  initial begin : back_pressure
    int unsigned run_left;
    int unsigned hold_left;
    int unsigned asks_seen;
    int unsigned r;
    run_left = 0;
    hold_left = 0;
    asks_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
      end else if (asks_seen != hold_off_asks) begin
        asks_seen = hold_off_asks;
        hold_left = 299;
        out_stall <= 1'b1;
      end else if (run_left != 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 8) begin
          out_stall <= 1'b1;
          run_left = $urandom_range(0, 2);
        end else if (r < 10) begin
          out_stall <= 1'b1;
          run_left = $urandom_range(14, 39);
        end else if (r < 18) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(0, 3);
        end else begin
          out_stall <= 1'b0;
          run_left = $urandom_range(29, 79);
        end
      end
    end
  end

  function automatic dir_row_t sample_row(input logic [7:0] s);
    dir_row_t r;
    r.kind = ROW_SAMPLE;
    r.idx = CFG_DELETE_SILENCE;
    r.val = s;
    r.known = 1'b0;
    r.has_out = 1'b0;
    r.exp_out = 8'h00;
    return r;
  endfunction

  function automatic logic [7:0] pick_sample(input logic want_loud);
    int unsigned mag;
    if (want_loud) mag = $urandom_range(0, cf_thr);
    else if (cf_thr == 7'd127) mag = $urandom_range(0, 127);
    else mag = $urandom_range(cf_thr + 1, 127);
    return {1'($urandom_range(0, 1)), 7'(mag)};
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 10) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic offer(input dir_row_t r, input logic no_gap);
    int unsigned g;
    offered_rows.push_back(r);
    @(negedge clk);
    in_valid <= 1'b1;
    sample_in <= r.val;
    do @(posedge clk); while (in_stall);
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a closed gate holding ring bytes must open before the ring length changes
  task automatic open_if_buffered();
    if (!gm_open && gm_skip != 0) begin
      offer(sample_row({1'($urandom_range(0, 1)), 7'd0}), 1'b1);
      settle();
    end
  endtask

  task automatic setup_phase(input logic del, input logic [6:0] thr,
                             input logic [5:0] hold, input logic [7:0] sil);
    settle();
    write_reg(CFG_DELETE_SILENCE, {7'($urandom), del});
    write_reg(CFG_LOUD_THRESHOLD, {1'($urandom), thr});
    write_reg(CFG_SILENCE_CODE, sil);
    open_if_buffered();
    write_reg(CFG_HOLD_LEN, {2'($urandom), hold});
  endtask

  task automatic run_bursts(input int unsigned n, input logic no_gap);
    int unsigned sent, len, qn, ln, k;
    sent = 0;
    while (sent < n) begin
      len = hold_in_use();
      if ($urandom_range(0, 6) == 0) begin
        offer(sample_row(8'($urandom)), no_gap);
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0: qn = $urandom_range(0, 2);
          1: qn = $urandom_range(len - 1, len + 1);
          2: qn = $urandom_range(len + 2, len + 6);
          default: qn = $urandom_range(0, len);
        endcase
        ln = $urandom_range(1, 3);
        for (k = 0; k < qn && sent < n; k++) begin
          offer(sample_row(pick_sample(1'b0)), no_gap);
          sent++;
        end
        for (k = 0; k < ln && sent < n; k++) begin
          offer(sample_row(pick_sample(1'b1)), no_gap);
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_DELETE_SILENCE;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_in = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        settle();
        if (DIRECTED[i].idx == CFG_HOLD_LEN) open_if_buffered();
        write_reg(DIRECTED[i].idx, DIRECTED[i].val);
      end else begin
        offer(DIRECTED[i], 1'b0);
      end
    end

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: setup_phase(1'b0, 7'd0, 6'd1, 8'($urandom));
        1: setup_phase(1'b1, 7'd127, 6'd63, 8'($urandom));
        2: setup_phase(1'b0, 7'd64, 6'd63, 8'($urandom));
        default: setup_phase(1'($urandom), 7'($urandom),
                             ($urandom_range(0, 2) == 0) ? 6'($urandom_range(1, 63))
                                                         : 6'($urandom_range(1, 12)),
                             8'($urandom));
      endcase
      // long receiver hold-off while requests keep coming
      if (ph == 2) hold_off_asks++;
      run_bursts(30, ph == 2);
    end

    settle();
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
